FILE: design/fbps_pkg.sv
// Package for the first-byte parity sum tracker.
// Transaction structs, command codes and the allowed-sum lookup.
// No dependencies.
`default_nettype none

package fbps_pkg;

  localparam int MAP_DEPTH = 256;
  localparam int BYTE_W    = 8;
  localparam int TALLY_W   = 9;

  // Command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic              command;
    logic [BYTE_W-1:0] nonce_top_byte;
    logic              parity_flag;
  } in_t;

  typedef struct packed {
    logic               was_new;
    logic [TALLY_W-1:0] distinct_count;
    logic [TALLY_W-1:0] parity_total;
    logic               total_is_valid;
  } out_t;

  // True for the 19 parity sums that a genuine first-byte set can produce
  function automatic logic sum_allowed(input logic [TALLY_W-1:0] s);
    logic ok;
    ok = 1'b0;
    case (s) inside
      9'd0, 9'd32, 9'd56, 9'd64, 9'd80, 9'd96, 9'd104, 9'd112, 9'd120,
      9'd128, 9'd136, 9'd144, 9'd152, 9'd160, 9'd176, 9'd192, 9'd200,
      9'd224, 9'd256: ok = 1'b1;
      default:        ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

FILE: design/fbps_in_reg.sv
// Input register stage of the first-byte parity sum tracker.
// Holds one accepted transaction until the core consumes it. Uses fbps_pkg.
`default_nettype none

module fbps_in_reg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire fbps_pkg::in_t in_data,
  output logic             s1_valid,
  output fbps_pkg::in_t    s1_data,
  input  wire logic        s1_take
);
  import fbps_pkg::*;

  logic valid_r;
  in_t  data_r;
  logic in_accept;

  // Stall only while holding an item that is not moving on this cycle
  assign in_stall  = valid_r & ~s1_take;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_accept) begin
      valid_r <= 1'b1;
    end else if (s1_take) begin
      valid_r <= 1'b0;
    end
  end

  // Payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_accept) begin
      data_r <= in_data;
    end
  end

  assign s1_valid = valid_r;
  assign s1_data  = data_r;

endmodule

`default_nettype wire

FILE: design/fbps_core.sv
// Tracker core: seen map, distinct count and parity sum.
// Computes the result for the staged item and commits state on take. Uses fbps_pkg.
`default_nettype none

module fbps_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fbps_pkg::in_t s1_data,
  input  wire logic          s1_take,
  output fbps_pkg::out_t     result
);
  import fbps_pkg::*;

  logic [MAP_DEPTH-1:0] seen_r;
  logic [TALLY_W-1:0]   distinct_r;
  logic [TALLY_W-1:0]   parity_r;

  logic                 is_clear;
  logic                 fresh;
  logic                 byte_par;
  logic [TALLY_W-1:0]   distinct_nxt;
  logic [TALLY_W-1:0]   parity_nxt;

  // Lookup and tally update for the staged item
  always_comb begin
    is_clear     = (s1_data.command == CMD_CLEAR);
    fresh        = ~is_clear & ~seen_r[s1_data.nonce_top_byte];
    byte_par     = (^s1_data.nonce_top_byte) ^ s1_data.parity_flag;
    distinct_nxt = distinct_r;
    parity_nxt   = parity_r;
    if (is_clear) begin
      distinct_nxt = '0;
      parity_nxt   = '0;
    end else if (fresh) begin
      distinct_nxt = distinct_r + TALLY_W'(1);
      parity_nxt   = parity_r + {{(TALLY_W-1){1'b0}}, byte_par};
    end
  end

  // State after the step is what the result reports
  always_comb begin
    result.was_new        = fresh;
    result.distinct_count = distinct_nxt;
    result.parity_total   = parity_nxt;
    result.total_is_valid = sum_allowed(parity_nxt);
  end

  // Commit: map bits and tallies, all cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      distinct_r <= '0;
      parity_r   <= '0;
    end else if (s1_take) begin
      distinct_r <= distinct_nxt;
      parity_r   <= parity_nxt;
      if (is_clear) begin
        seen_r <= '0;
      end else if (fresh) begin
        seen_r[s1_data.nonce_top_byte] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/fbps_out_reg.sv
// Result register stage of the first-byte parity sum tracker.
// Loads one result per cycle when free or draining. Uses fbps_pkg.
`default_nettype none

module fbps_out_reg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           s1_valid,
  output logic                s1_take,
  input  wire fbps_pkg::out_t result,
  output logic                out_valid,
  input  wire logic           out_stall,
  output fbps_pkg::out_t      out_data
);
  import fbps_pkg::*;

  logic valid_r;
  out_t data_r;

  // Free when empty or when the held result leaves this cycle
  assign s1_take = s1_valid & (~valid_r | ~out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (s1_take) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

FILE: design/first_byte_parity_sum_tracker.sv
// First-byte parity sum tracker, top level. Uses fbps_pkg, fbps_in_reg,
// fbps_core and fbps_out_reg.
// Pipeline: 2 register stages, fbps_in_reg and then fbps_out_reg (the result register).
// Throughput: 1 transaction per cycle while out_stall is low, set by the read-modify-write
// of the 256-bit seen map and the two tally adders in fbps_core.
// Reset: synchronous rst_n clears the seen map, both tallies and all valids.
`default_nettype none

module first_byte_parity_sum_tracker (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire fbps_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output fbps_pkg::out_t      out_data
);
  import fbps_pkg::*;

  logic s1_valid;
  logic s1_take;
  in_t  s1_data;
  out_t result;

  fbps_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_take  (s1_take)
  );

  fbps_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_data (s1_data),
    .s1_take (s1_take),
    .result  (result)
  );

  fbps_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_take   (s1_take),
    .result    (result),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: design/fbps_checker.sv
// Port-level checker for the first-byte parity sum tracker, bound to the top.
// Uses fbps_pkg.
`default_nettype none

module fbps_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire fbps_pkg::out_t out_data
);
  import fbps_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A new byte always leaves a nonzero count
  a_new_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_new |-> out_data.distinct_count != '0)
    else $error("new byte reported with zero count");

  // Each distinct byte adds at most one to the sum
  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.parity_total <= out_data.distinct_count)
    else $error("parity sum exceeds distinct count");

  // Empty state reports a zero, allowed sum
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.distinct_count == '0 |->
      out_data.parity_total == '0 && out_data.total_is_valid)
    else $error("empty state reports wrong sum");

endmodule

bind first_byte_parity_sum_tracker fbps_checker u_fbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
